/* rtl/mh3_pkg.sv */
package mh3_pkg;

    // mixing constants
    localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2 = 32'h1b873593;
    localparam logic [31:0] MUR_N  = 32'he6546b64;
    localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one word command: a full word or the tail of a message
    typedef struct packed {
        logic [31:0] word;
        logic        full;
        logic        last;
        logic        first;
        logic [31:0] seed;
        logic [31:0] length;
    } mh3_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROT,
        BK_MIX,
        BK_FIN0,
        BK_FIN1,
        BK_FIN2
    } bk_state_t;

endpackage

/* rtl/mh3_front.sv */
module mh3_front
    import mh3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_seed,
    input  logic        s_last_byte,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output mh3_cmd_t    cmd
);

    logic [23:0] word_reg;
    logic [1:0]  lane_reg;
    logic [31:0] len_reg;
    logic        in_msg_reg;
    logic [31:0] seed_reg;
    logic        first_pend_reg;

    logic        accept;
    logic        push;
    logic [31:0] word_cur;
    logic [31:0] len_cur;

    assign s_ready = cmd_ready;
    assign accept  = s_valid && cmd_ready;

    // merge the byte into its lane
    assign word_cur = {8'h00, word_reg} | ({24'h000000, s_data_byte} << {lane_reg, 3'b000});
    assign len_cur  = len_reg + 32'd1;

    // a full word or the end of a message becomes a request to the back end
    assign push      = accept && ((lane_reg == 2'd3) || s_last_byte);
    assign cmd_valid = push;

    always_comb begin
        cmd.word   = word_cur;
        cmd.full   = (lane_reg == 2'd3);
        cmd.last   = s_last_byte;
        cmd.first  = first_pend_reg || !in_msg_reg;
        cmd.seed   = in_msg_reg ? seed_reg : s_seed;
        cmd.length = len_cur;
    end

    // byte gathering state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg       <= '0;
            lane_reg       <= '0;
            len_reg        <= '0;
            in_msg_reg     <= 1'b0;
            first_pend_reg <= 1'b0;
        end else if (accept) begin
            if (!in_msg_reg) begin
                seed_reg <= s_seed;
            end
            if (push) begin
                word_reg       <= '0;
                first_pend_reg <= 1'b0;
            end else begin
                word_reg       <= word_cur[23:0];
                first_pend_reg <= first_pend_reg || !in_msg_reg;
            end
            if (s_last_byte) begin
                lane_reg   <= '0;
                len_reg    <= '0;
                in_msg_reg <= 1'b0;
            end else begin
                lane_reg   <= lane_reg + 2'd1;
                len_reg    <= len_cur;
                in_msg_reg <= 1'b1;
            end
        end
    end

endmodule

/* rtl/mh3_queue.sv */
module mh3_queue
    import mh3_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  mh3_cmd_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output mh3_cmd_t out_data
);

    mh3_cmd_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  wr_en;
    logic                  rd_en;

    assign in_ready  = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

/* rtl/mh3_back.sv */
module mh3_back
    import mh3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  mh3_cmd_t    cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    bk_state_t   state_reg;
    bk_state_t   state_next;
    logic [31:0] h_reg;
    logic [31:0] k_reg;
    logic        full_reg;
    logic        last_reg;
    logic [31:0] len_reg;
    logic [31:0] hash_reg;
    logic        out_valid_reg;

    logic        slot_free;
    logic [31:0] mix_x;
    logic [31:0] mix_r;
    logic [31:0] mix_h;
    logic [31:0] fin0_x;
    logic [31:0] fin1_x;

    assign slot_free    = !out_valid_reg || m_ready;
    assign cmd_ready    = (state_reg == BK_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_hash_value = hash_reg;

    // word fold into the running hash, times five as shift and add
    assign mix_x  = h_reg ^ k_reg;
    assign mix_r  = {mix_x[18:0], mix_x[31:19]};
    assign mix_h  = (full_reg ? ((mix_r << 2) + mix_r + MUR_N) : mix_x)
                    ^ (last_reg ? len_reg : 32'h0);
    assign fin0_x = h_reg ^ (h_reg >> 16);
    assign fin1_x = k_reg ^ (k_reg >> 13);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    state_next = BK_ROT;
                end
            end
            BK_ROT:  state_next = BK_MIX;
            BK_MIX:  state_next = last_reg ? BK_FIN0 : BK_IDLE;
            BK_FIN0: state_next = BK_FIN1;
            BK_FIN1: state_next = BK_FIN2;
            BK_FIN2: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath, at most one multiply per step
    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    k_reg    <= cmd.word * MUR_C1;
                    h_reg    <= cmd.first ? cmd.seed : h_reg;
                    full_reg <= cmd.full;
                    last_reg <= cmd.last;
                    len_reg  <= cmd.length;
                end
            end
            BK_ROT:  k_reg <= {k_reg[16:0], k_reg[31:17]} * MUR_C2;
            BK_MIX:  h_reg <= mix_h;
            BK_FIN0: k_reg <= fin0_x * MUR_F1;
            BK_FIN1: k_reg <= fin1_x * MUR_F2;
            BK_FIN2: begin
                if (slot_free) begin
                    hash_reg <= k_reg ^ (k_reg >> 16);
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == BK_FIN2 && slot_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/murmur3_hash_engine.sv */
// channel | ports                                  | request
// --------+----------------------------------------+------------------------------
// input   | s_valid s_ready s_data_byte s_seed     | one message byte, seed taken
//         | s_last_byte                            | on the first byte
// result  | m_valid m_ready m_hash_value           | 32-bit hash per message
//
// the front end takes one byte per cycle while the command queue has room
// the back end takes each word request in idle and steps it through rot and mix,
// a last word also through fin0, fin1 and fin2, which loads the output register;
// long messages run at one byte a cycle (front bound) while the queue has room
// reset is synchronous and clears the control state only, no clearing pass
// a stalled result holds in the output register; the queue fills behind it
module murmur3_hash_engine
    import mh3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_seed,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    mh3_cmd_t fr_cmd;
    logic     fr_valid;
    logic     fr_ready;
    mh3_cmd_t bk_cmd;
    logic     bk_valid;
    logic     bk_ready;

    // byte gathering
    mh3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .s_seed     (s_seed),
        .s_last_byte(s_last_byte),
        .cmd_valid  (fr_valid),
        .cmd_ready  (fr_ready),
        .cmd        (fr_cmd)
    );

    // word command queue
    mh3_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fr_valid),
        .in_ready (fr_ready),
        .in_data  (fr_cmd),
        .out_valid(bk_valid),
        .out_ready(bk_ready),
        .out_data (bk_cmd)
    );

    // mixing and finaliser
    mh3_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (bk_valid),
        .cmd_ready   (bk_ready),
        .cmd         (bk_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash_value(m_hash_value)
    );

endmodule

/* rtl/mh3_checker.sv */
module mh3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_hash_value
);

    logic [3:0] pending_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_valid && s_ready && s_last_byte;
    assign m_fire = m_valid && m_ready;

    // messages ended on the input but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + {3'b000, s_fire} - {3'b000, m_fire};
        end
    end

    // a stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // every result belongs to a message whose last byte was taken
    a_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 4'd0)
        else $error("result without a finished message");

    // messages in flight stay at or below eight, above what the pipeline can hold
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'd8)
        else $error("too many messages in flight");

endmodule

bind murmur3_hash_engine mh3_checker u_mh3_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_last_byte (s_last_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hash_value(m_hash_value)
);

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic [31:0] s_seed = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_hash_value;

    // predicted hashes, oldest first
    logic [31:0] hash_q[$];

    // shadow of the hashing state
    logic [31:0] acc_hash = '0;
    logic [31:0] word_acc = '0;
    logic [1:0]  lane_idx = '0;
    logic [31:0] byte_count = '0;
    logic        mid_message = 1'b0;

    int          no_idle = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          mismatch_count = 0;
    int          hashes_checked = 0;
    int          bytes_sent = 0;
    int          messages_sent = 0;
    logic [31:0] want_hash;

    murmur3_hash_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_seed       (s_seed),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * mh3_pkg::MUR_C1;
        t = rotl(t, 15);
        return t * mh3_pkg::MUR_C2;
    endfunction

    // advance the shadow state by one byte, returns 1 when a hash is due
    function automatic bit absorb_byte(input logic [7:0] b, input logic [31:0] sd,
                                       input logic lst, output logic [31:0] hash);
        logic [31:0] h;
        hash = '0;
        if (!mid_message) begin
            acc_hash = sd;
            word_acc = '0;
            lane_idx = '0;
            byte_count = '0;
            mid_message = 1'b1;
        end
        word_acc = word_acc | (32'(b) << (8 * lane_idx));
        byte_count = byte_count + 32'd1;
        lane_idx = lane_idx + 2'd1;
        // full word mixed into the running hash
        if (lane_idx == 2'd0) begin
            h = rotl(acc_hash ^ scramble_word(word_acc), 13);
            acc_hash = h * 32'd5 + mh3_pkg::MUR_N;
            word_acc = '0;
        end
        if (!lst)
            return 1'b0;
        // tail, length and avalanche
        h = acc_hash;
        if (lane_idx != 2'd0)
            h = h ^ scramble_word(word_acc);
        h = h ^ byte_count;
        h = h ^ (h >> 16);
        h = h * mh3_pkg::MUR_F1;
        h = h ^ (h >> 13);
        h = h * mh3_pkg::MUR_F2;
        h = h ^ (h >> 16);
        hash = h;
        acc_hash = '0;
        word_acc = '0;
        lane_idx = '0;
        byte_count = '0;
        mid_message = 1'b0;
        return 1'b1;
    endfunction

    // offer one request and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic [31:0] sd, input logic lst);
        logic [31:0] hash;
        if (no_idle == 0 && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_seed <= sd;
        s_last_byte <= lst;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (absorb_byte(b, sd, lst, hash)) begin
            hash_q.push_back(hash);
            messages_sent++;
        end
    endtask

    // whole message with random content, seed noise on later bytes if asked
    task automatic send_message(input int len, input logic [31:0] sd, input bit seed_noise);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            send_byte(b, (i > 0 && seed_noise) ? $urandom : sd, i == len - 1);
        end
    endtask

    // result side: random ready, long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (no_idle != 0) || ($urandom_range(99) >= 16);
        end
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            hashes_checked++;
            if (hash_q.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected hash %08h at cycle %0d", m_hash_value, cycle_count);
            end else begin
                want_hash = hash_q.pop_front();
                if (m_hash_value !== want_hash) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("hash mismatch: expected %08h actual %08h at cycle %0d",
                                 want_hash, m_hash_value, cycle_count);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // extremes of bytes and seeds, every tail length, seed changes mid message
    task automatic test_directed();
        send_byte(8'h00, 32'h0000_0000, 1'b1);
        send_byte(8'hff, 32'hffff_ffff, 1'b1);
        send_byte(8'h01, 32'h8000_0001, 1'b0);
        send_byte(8'hfe, 32'h1234_5678, 1'b1);
        send_message(3, 32'hffff_ffff, 1'b0);
        send_message(4, 32'h0000_0000, 1'b0);
        send_message(5, 32'hdead_beef, 1'b1);
        for (int i = 0; i < 8; i++)
            send_byte(8'hff, ~32'(i), i == 7);
    endtask

    // mostly short messages, some longer, with a stretch free of gaps and stalls in the middle
    task automatic test_random_messages();
        int len;
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 700) begin
            if (bytes_sent - start > 250 && bytes_sent - start < 450)
                no_idle = 1;
            else
                no_idle = 0;
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            send_message(len, $urandom, $urandom_range(1) == 1);
        end
        no_idle = 0;
    endtask

    // receiver holds off while short messages keep coming, input must stall
    task automatic test_output_stall();
        hold_requests++;
        for (int i = 0; i < 30; i++)
            send_message($urandom_range(1, 5), $urandom, 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (hash_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_messages();
        test_output_stall();
        drain();
        fail_count += hash_q.size();
        $display("ran %0d messages over %0d bytes, %0d hashes checked",
                 messages_sent, bytes_sent, hashes_checked);
        $display("tail lengths 0-3, seed noise, random gaps and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
